### rtl/wsm_pkg.sv
// Shared types and constants for the wildcard star pattern matcher.
package wsm_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int POS_COUNT    = MAX_ELEMENTS + 1;
  localparam int POS_W        = $clog2(POS_COUNT);
  localparam int CFG_W        = 5;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BYTE  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef struct packed {
    logic [7:0] lit;
    logic       any;
    logic       star;
  } elem_t;

  // Signals handed from one position cell to the next.
  typedef struct packed {
    logic closure;
    logic advance;
  } link_t;

  // Per-cycle controls given to each cell; all but wr_en are the same for every cell.
  typedef struct packed {
    logic       step;
    logic       restart;
    logic       wr_en;
    logic [7:0] text_byte;
  } cell_ctrl_t;

endpackage

### rtl/wsm_cell.sv
// One pattern position: its table entry, its live bit and its match logic.
module wsm_cell
  import wsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [POS_W-1:0] cell_index,
  input  logic [POS_W-1:0] len,
  input  cell_ctrl_t       ctrl,
  input  elem_t            wr_elem,
  input  link_t            link_in,
  output link_t            link_out,
  output logic             cur,
  output logic             at_end
);

  elem_t entry;
  logic  live;
  logic  live_next;
  logic  in_range;
  logic  elem_ok;
  logic  hit;

  assign in_range = (cell_index <= len);
  assign elem_ok  = (cell_index < len);
  assign cur      = in_range & (live | link_in.closure);
  assign at_end   = cur & (cell_index == len);
  assign hit      = cur & elem_ok & (entry.any | (entry.lit == ctrl.text_byte));

  assign link_out.closure = cur & elem_ok & entry.star;
  assign link_out.advance = hit & ~entry.star;

  always_comb begin
    if (ctrl.step) begin
      live_next = (hit & entry.star) | link_in.advance;
    end else if (ctrl.restart) begin
      live_next = (cell_index == '0);
    end else begin
      live_next = live;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= (cell_index == '0);
    end else begin
      live <= live_next;
    end
  end

  // table entry carries no reset
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      entry <= wr_elem;
    end
  end

endmodule

### rtl/wildcard_star_pattern_matcher_core.sv
// Top level of the wildcard star pattern matcher: cell chain and result register.
//
// Usage:
//   Write pattern_length through pattern_length_we / pattern_length while idle.
//   Requests arrive on item_valid / item_ready; opcode selects the action:
//     OP_WRITE loads table slot elem_index with {elem_byte, elem_any, elem_star},
//     OP_BYTE  advances every position cell by text_byte,
//     OP_END   reports the match and restarts at position zero.
//   Only OP_END yields a result, on result_valid / result_ready, carrying
//   matched (final position live) and any_live (some position live).
// Throughput: one request per cycle while not stalled; every cell updates in parallel, and the
//   star closure ripples through the chain of cells within the cycle.
// Output: the result is registered and shows in the cycle after OP_END is taken.
// Stall: while a result waits, writes and text bytes are still taken; only a
//   further OP_END is held off until the result register drains.
// Reset: clears the live set to position zero, the length to zero and the
//   result_valid flag; table contents stay undefined until written.
module wildcard_star_pattern_matcher_core
  import wsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pattern_length_we,
  input  logic [CFG_W-1:0] pattern_length,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [1:0]       opcode,
  input  logic [3:0]       elem_index,
  input  logic [7:0]       elem_byte,
  input  logic             elem_any,
  input  logic             elem_star,
  input  logic [7:0]       text_byte,
  output logic             result_valid,
  input  logic             result_ready,
  output logic             matched,
  output logic             any_live
);

  logic [CFG_W-1:0]     len_reg;
  logic [POS_W-1:0]     len;
  logic                 item_fire;
  op_t                  op;
  elem_t                wr_elem;
  link_t                links [POS_COUNT+1];
  logic [POS_COUNT-1:0] cur_vec;
  logic [POS_COUNT-1:0] end_vec;
  logic [POS_COUNT-1:0] wr_sel;
  cell_ctrl_t           ctrl [POS_COUNT];

  assign op        = op_t'(opcode);
  assign item_ready = (op != OP_END) | ~result_valid | result_ready;
  assign item_fire = item_valid & item_ready;

  // Saturate the length at the table depth.
  always_comb begin
    if (32'(len_reg) > MAX_ELEMENTS) begin
      len = POS_W'(MAX_ELEMENTS);
    end else begin
      len = POS_W'(len_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= '0;
    end else if (pattern_length_we) begin
      len_reg <= pattern_length;
    end
  end

  assign wr_elem.lit  = elem_byte;
  assign wr_elem.any  = elem_any;
  assign wr_elem.star = elem_star;

  assign links[0] = '0;

  for (genvar k = 0; k < POS_COUNT; k++) begin : g_cell
    // the final position has no element and is never written
    assign wr_sel[k] = (k < MAX_ELEMENTS) && (32'(elem_index) == k);

    assign ctrl[k].step      = item_fire & (op == OP_BYTE);
    assign ctrl[k].restart   = item_fire & (op == OP_END);
    assign ctrl[k].wr_en     = item_fire & (op == OP_WRITE) & wr_sel[k];
    assign ctrl[k].text_byte = text_byte;

    wsm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (POS_W'(k)),
      .len        (len),
      .ctrl       (ctrl[k]),
      .wr_elem    (wr_elem),
      .link_in    (links[k]),
      .link_out   (links[k+1]),
      .cur        (cur_vec[k]),
      .at_end     (end_vec[k])
    );
  end

  // Load the result on end of text; drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_fire && op == OP_END) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && op == OP_END) begin
      matched  <= |end_vec;
      any_live <= |cur_vec;
    end
  end

`ifndef SYNTHESIS
  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid & item_ready & (opcode == OP_END)))
    else $error("result appeared without an end-of-text request");

  a_restart_pos0: assert property (@(posedge clk) disable iff (rst)
    (item_valid & item_ready & (opcode == OP_END)) |=> (cur_vec[0] == 1'b1))
    else $error("position zero not live after restart");

  a_match_implies_live: assert property (@(posedge clk) disable iff (rst)
    (result_valid & matched) |-> any_live)
    else $error("match reported with no live position");

  a_stall_only_end: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (result_valid & !result_ready & (opcode == OP_END)))
    else $error("request held off without a pending result");
`endif

endmodule
